[rtl/ifp_pkg.sv]
// Shared types, codes and constants of the IMU frame parser.
package ifp_pkg;

  // Frame phases
  typedef enum logic [2:0] {
    PH_PRE = 3'd0,
    PH_BUS = 3'd1,
    PH_MSG = 3'd2,
    PH_LEN = 3'd3,
    PH_PAY = 3'd4,
    PH_CHK = 3'd5
  } phase_t;

  localparam logic [7:0]  PREAMBLE     = 8'hFA;
  localparam logic [7:0]  MSG_SAMPLE   = 8'h36;
  localparam logic [15:0] TAG_ACCEL    = 16'h4020;
  localparam logic [15:0] TAG_RATE     = 16'h8020;
  localparam logic [7:0]  LEN_EXTENDED = 8'hFF;
  localparam logic [7:0]  VEC_SIZE     = 8'd12;

  // Q.32 scale factors: 2^32/9.80665 and 57.2957795*2^32
  localparam int          SCALE_W   = 38;
  localparam int          SCALE_LO  = 19;
  localparam logic [37:0] SCALE_G   = 38'd437964779;
  localparam logic [37:0] SCALE_DPS = 38'd246083499151;

  localparam int FRAC_BITS_DEF = 16;

  // Value slots
  localparam logic [1:0] SLOT_AX = 2'd0;
  localparam logic [1:0] SLOT_AY = 2'd1;
  localparam logic [1:0] SLOT_YZ = 2'd2;

  // Float conversion request from the parser
  typedef struct packed {
    logic        valid;
    logic [31:0] bits;
    logic        is_dps;
    logic [1:0]  slot;
  } conv_req_t;

  // One output sample
  typedef struct packed {
    logic signed [31:0] accel_x_g;
    logic signed [31:0] accel_y_g;
    logic signed [31:0] yaw_rate_dps;
  } sample_t;

endpackage

[rtl/ifp_stream_if.sv]
// Valid/ready channel interfaces for the byte input and the sample output.
interface ifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_x_g;
  logic signed [31:0] accel_y_g;
  logic signed [31:0] yaw_rate_dps;
  modport source (output valid, output accel_x_g, output accel_y_g, output yaw_rate_dps,
                  input ready);
  modport sink   (input valid, input accel_x_g, input accel_y_g, input yaw_rate_dps,
                  output ready);
endinterface

[rtl/ifp_frame_fsm.sv]
// Byte-level frame parser: phases, checksum, item walk and emit decision.
module ifp_frame_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output ifp_pkg::conv_req_t req,
  output logic               emit
);

  ifp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  msg_r, msg_nxt, len_r, len_nxt, seen_r, seen_nxt, sum_r, sum_nxt;
  logic [1:0]  hpos_r, hpos_nxt, marks_r, marks_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [7:0]  size_r, size_nxt, left_r, left_nxt, idx;
  logic [31:0] word_r, word_nxt;
  logic        fin;
  logic [7:0]  sum_add;

  assign sum_add = sum_r + rx_byte;
  assign idx     = size_r - left_r;
  assign fin     = (word_nxt[30:23] != 8'hFF);

  always_comb begin
    phase_nxt = phase_r;
    msg_nxt   = msg_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    sum_nxt   = sum_r;
    hpos_nxt  = hpos_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    word_nxt  = word_r;
    marks_nxt = marks_r;
    req       = '0;
    req.bits  = word_nxt;
    emit      = 1'b0;
    if (take) begin
      case (phase_r)
        ifp_pkg::PH_BUS: begin
          sum_nxt   = rx_byte;
          phase_nxt = ifp_pkg::PH_MSG;
        end
        ifp_pkg::PH_MSG: begin
          msg_nxt   = rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = ifp_pkg::PH_LEN;
        end
        ifp_pkg::PH_LEN: begin
          len_nxt   = rx_byte;
          sum_nxt   = sum_add;
          seen_nxt  = '0;
          hpos_nxt  = '0;
          left_nxt  = '0;
          size_nxt  = '0;
          tag_nxt   = '0;
          marks_nxt = '0;
          if (rx_byte == 8'd0) phase_nxt = ifp_pkg::PH_CHK;
          else if (rx_byte == ifp_pkg::LEN_EXTENDED) phase_nxt = ifp_pkg::PH_PRE;
          else phase_nxt = ifp_pkg::PH_PAY;
        end
        ifp_pkg::PH_PAY: begin
          sum_nxt  = sum_add;
          seen_nxt = seen_r + 8'd1;
          if (left_r == 8'd0) begin
            // item header: tag high, tag low, size
            case (hpos_r)
              2'd0: begin
                tag_nxt  = {rx_byte, 8'h00};
                hpos_nxt = 2'd1;
              end
              2'd1: begin
                tag_nxt  = {tag_r[15:8], rx_byte};
                hpos_nxt = 2'd2;
              end
              default: begin
                size_nxt = rx_byte;
                left_nxt = rx_byte;
                hpos_nxt = 2'd0;
              end
            endcase
          end else begin
            // item data: shift in and launch conversions on word boundaries
            word_nxt = {word_r[23:0], rx_byte};
            left_nxt = left_r - 8'd1;
            req.bits = {word_r[23:0], rx_byte};
            if (size_r == ifp_pkg::VEC_SIZE) begin
              if (tag_r == ifp_pkg::TAG_ACCEL && idx == 8'd3) begin
                req.valid = 1'b1;
                req.slot  = ifp_pkg::SLOT_AX;
                marks_nxt = {marks_r[1], fin};
              end else if (tag_r == ifp_pkg::TAG_ACCEL && idx == 8'd7) begin
                req.valid = 1'b1;
                req.slot  = ifp_pkg::SLOT_AY;
                marks_nxt = {marks_r[1], marks_r[0] & fin};
              end else if (tag_r == ifp_pkg::TAG_RATE && idx == 8'd11) begin
                req.valid  = 1'b1;
                req.is_dps = 1'b1;
                req.slot   = ifp_pkg::SLOT_YZ;
                marks_nxt  = {fin, marks_r[0]};
              end
            end
          end
          if (seen_nxt == len_r) phase_nxt = ifp_pkg::PH_CHK;
        end
        ifp_pkg::PH_CHK: begin
          sum_nxt   = sum_add;
          phase_nxt = ifp_pkg::PH_PRE;
          emit = (sum_add == 8'd0) && (msg_r == ifp_pkg::MSG_SAMPLE) &&
                 (hpos_r == 2'd0) && (left_r == 8'd0) && (marks_r == 2'b11);
        end
        default: begin
          phase_nxt = (rx_byte == ifp_pkg::PREAMBLE) ? ifp_pkg::PH_BUS : ifp_pkg::PH_PRE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ifp_pkg::PH_PRE;
      msg_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
      hpos_r  <= '0;
      tag_r   <= '0;
      size_r  <= '0;
      left_r  <= '0;
      word_r  <= '0;
      marks_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      msg_r   <= msg_nxt;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
      hpos_r  <= hpos_nxt;
      tag_r   <= tag_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
      word_r  <= word_nxt;
      marks_r <= marks_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_emit_on_chk: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (phase_r == ifp_pkg::PH_CHK)) else $error("emit outside checksum phase");
  a_req_in_pay: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (phase_r == ifp_pkg::PH_PAY && take)) else $error("stray conversion");
  a_emit_next_pre: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (phase_r == ifp_pkg::PH_PRE)) else $error("no return to hunt after emit");
`endif

endmodule

[rtl/ifp_fix_conv.sv]
// Float to saturating fixed-point conversion pipeline, held values, emit delay.
module ifp_fix_conv #(
  parameter int FRAC_BITS = ifp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ifp_pkg::conv_req_t req,
  input  logic               emit,
  output logic               push,
  output ifp_pkg::sample_t   sample
);

  localparam int SOFF = FRAC_BITS - 182;  // exponent bias, mantissa and Q.32 offsets
  localparam int HI_W = ifp_pkg::SCALE_W - ifp_pkg::SCALE_LO;

  // stage A: captured float
  logic        a_v_r, a_dps_r;
  logic [31:0] a_bits_r;
  logic [1:0]  a_slot_r;
  // stage B: partial products
  logic        b_v_r, b_neg_r, b_fin_r;
  logic [7:0]  b_ex_r;
  logic [1:0]  b_slot_r;
  logic [23:0] a_m;
  logic [37:0] a_scale;
  logic [42:0] b_lo_r;
  logic [42:0] b_hi_r;
  // stage C: full product
  logic        c_v_r, c_neg_r, c_fin_r;
  logic [7:0]  c_ex_r;
  logic [1:0]  c_slot_r;
  logic [61:0] c_p_r;
  // held values and emit delay
  logic [31:0] held_r [3];
  logic        e1_r, e2_r, e3_r;

  assign a_m     = (a_bits_r[30:23] == 8'd0) ? {1'b0, a_bits_r[22:0]} : {1'b1, a_bits_r[22:0]};
  assign a_scale = a_dps_r ? ifp_pkg::SCALE_DPS : ifp_pkg::SCALE_G;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      e1_r  <= 1'b0;
      e2_r  <= 1'b0;
      e3_r  <= 1'b0;
    end else begin
      a_v_r <= req.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      e1_r  <= emit;
      e2_r  <= e1_r;
      e3_r  <= e2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    a_bits_r <= req.bits;
    a_dps_r  <= req.is_dps;
    a_slot_r <= req.slot;
    b_lo_r   <= a_m * a_scale[ifp_pkg::SCALE_LO-1:0];
    b_hi_r   <= a_m * a_scale[ifp_pkg::SCALE_W-1:ifp_pkg::SCALE_LO];
    b_neg_r  <= a_bits_r[31];
    b_fin_r  <= (a_bits_r[30:23] != 8'hFF);
    b_ex_r   <= (a_bits_r[30:23] == 8'd0) ? 8'd1 : a_bits_r[30:23];
    b_slot_r <= a_slot_r;
    c_p_r    <= {b_hi_r[HI_W+23:0], {ifp_pkg::SCALE_LO{1'b0}}} + {19'd0, b_lo_r};
    c_neg_r  <= b_neg_r;
    c_fin_r  <= b_fin_r;
    c_ex_r   <= b_ex_r;
    c_slot_r <= b_slot_r;
  end

  // stage D: scale, round half away from zero, saturate
  logic signed [9:0] s;
  logic        [9:0] k;
  logic       [31:0] lim, res;
  logic       [63:0] mag, rnd;
  always_comb begin
    s   = $signed({2'b00, c_ex_r}) + 10'(SOFF);
    k   = 10'(-s);
    lim = c_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    rnd = '0;
    if (c_p_r == 62'd0) begin
      mag = '0;
    end else if (!s[9]) begin
      if (s >= 10'sd32 || c_p_r > ({30'd0, lim} >> s[4:0])) mag = {32'd0, lim};
      else mag = {32'd0, 32'(c_p_r << s[4:0])};
    end else begin
      if (k >= 10'd64) begin
        mag = '0;
      end else begin
        rnd = {2'b00, c_p_r} + (64'd1 << (k[5:0] - 6'd1));
        mag = rnd >> k[5:0];
      end
      if (mag > {32'd0, lim}) mag = {32'd0, lim};
    end
    if (!c_fin_r) res = '0;
    else res = c_neg_r ? 32'(32'd0 - mag[31:0]) : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0] <= '0;
      held_r[1] <= '0;
      held_r[2] <= '0;
    end else if (c_v_r) begin
      held_r[c_slot_r] <= res;
    end
  end

  assign push                = e3_r;
  assign sample.accel_x_g    = held_r[0];
  assign sample.accel_y_g    = held_r[1];
  assign sample.yaw_rate_dps = held_r[2];

`ifndef ASSERT_OFF
  a_push_settled: assert property (@(posedge clk) disable iff (!rst_n)
    e3_r |-> !(a_v_r || b_v_r || c_v_r)) else $error("sample read during conversion");
  a_emit_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({e1_r, e2_r, e3_r})) else $error("emits too close together");
`endif

endmodule

[rtl/ifp_out_buf.sv]
// Two-entry output register with skid stage for the sample channel.
module ifp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ifp_pkg::sample_t pdata,
  output logic             room,
  ifp_out_if.source        out_ch
);

  logic             v0_r, v0_nxt, v1_r, v1_nxt;
  ifp_pkg::sample_t d0_r, d0_nxt, d1_r, d1_nxt;
  logic             pop;

  assign pop  = v0_r & out_ch.ready;
  assign room = !v1_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      v0_nxt = v1_r;
      d0_nxt = d1_r;
      v1_nxt = 1'b0;
    end
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        d0_nxt = pdata;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = pdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign out_ch.valid        = v0_r;
  assign out_ch.accel_x_g    = d0_r.accel_x_g;
  assign out_ch.accel_y_g    = d0_r.accel_y_g;
  assign out_ch.yaw_rate_dps = d0_r.yaw_rate_dps;

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r) else $error("skid full with head empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && v1_r) |-> pop) else $error("sample lost on full buffer");
`endif

endmodule

[rtl/imu_frame_parser.sv]
// Top level of the IMU frame parser.
//
// in_ch carries one received byte per request (valid/ready). The parser hunts
// for the preamble, checks the mod-256 checksum and decodes acceleration and
// rate-of-turn items of sample messages on the fly. out_ch carries one sample
// (x/y acceleration in g, yaw rate in deg/s, signed Q.FRAC_BITS) per good frame.
// Throughput: one byte per cycle while in_ch.ready is high. The emit strobe
// of the checksum byte passes registers e1_r, e2_r and e3_r, which cover the
// float conversion pipeline (two partial products, a sum, then round/saturate).
// The output side has a result register plus a skid entry: bytes keep
// flowing while a sample waits, and in_ch.ready drops only when both hold a
// sample (the receiver has stalled through a whole further frame).
// Synchronous active-low reset returns the parser to the preamble hunt,
// clears held values and empties the output buffer.
module imu_frame_parser #(
  parameter int FRAC_BITS = ifp_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ifp_in_if.sink     in_ch,
  ifp_out_if.source  out_ch
);

  logic               room, take, emit, push;
  ifp_pkg::conv_req_t req;
  ifp_pkg::sample_t   sample;

  assign in_ch.ready = room;
  assign take        = in_ch.valid & room;

  ifp_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.rx_byte),
    .req     (req),
    .emit    (emit)
  );

  ifp_fix_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .emit   (emit),
    .push   (push),
    .sample (sample)
  );

  ifp_out_buf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pdata  (sample),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
